FILE: rtl/ntq_pkg.sv
// Shared constants, codes and types for the tiered task queue.
package ntq_pkg;

  localparam int NODES_MAX = 4;
  localparam int TIERS     = 3;
  localparam int QDL       = 10;
  localparam int QCAP      = 1 << QDL;
  localparam int NQ        = NODES_MAX * TIERS;
  localparam int BATCH_MAX = 8;

  localparam int QIW     = $clog2(NQ);
  localparam int ADDR_W  = QIW + QDL;
  localparam int CNT_W   = QDL + 1;
  localparam int DEPTH_W = CNT_W + 1;
  localparam int TAG_W   = 32;
  localparam int NODE_W  = 2;
  localparam int WORD_W  = TAG_W + NODE_W;
  localparam int NCNT_W  = 3;
  localparam int THR_W   = 12;
  localparam int BATCH_W = 4;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_REBAL = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_NO_TASK   = 3'd3,
    ST_REBAL     = 3'd4
  } status_t;

  typedef enum logic {
    CFG_ACTIVE_NODES = 1'b0,
    CFG_STEAL_THR    = 1'b1
  } cfg_idx_t;

  localparam logic [1:0] TIER_HIGH   = 2'd0;
  localparam logic [1:0] TIER_NORMAL = 2'd1;
  localparam logic [1:0] TIER_LOW    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_DQ_LOOK,
    S_DQ_WAIT,
    S_STEAL,
    S_DQ_DONE,
    S_RB_SCAN,
    S_RB_CHECK,
    S_RB_POP,
    S_RB_WAIT,
    S_RB_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  function automatic logic [QIW-1:0] qidx(input logic [NODE_W-1:0] n,
                                          input logic [1:0] t);
    qidx = QIW'(n) * QIW'(TIERS) + QIW'(t);
  endfunction

endpackage

FILE: rtl/ntq_store.sv
// Task store: one write port, one registered read port.
module ntq_store
  import ntq_pkg::*;
(
  input  logic              clk,
  input  store_req_t        req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [NQ*QCAP];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/numa_tiered_task_queue.sv
// Top level: sequencer, queue pointers and result register of the tiered task queue.
//
// Per-node FIFO task queues in three tiers (high, normal, low), up to four
// nodes, each queue 1024 tasks deep in one shared 12288-entry task store.
// One command is taken at a time; in_ready is high only while the sequencer
// is idle. Every step goes through the store ports and the single
// queue-pointer update path, one queue per cycle: an enqueue pushes the task,
// falling through one tier if its queue is full; a dequeue pops each
// delivered task and probes each empty tier or steal victim in turn; a
// rebalance scans every active node, then pops and pushes each task moved.
// Results sit in an output register, so the next command is accepted while
// the last result still waits to be taken. The store is not cleared at reset;
// queue pointers and counts are. Configuration is written through cfg_we,
// cfg_index and cfg_data, by the user only while idle; the block does not enforce it.
module numa_tiered_task_queue
  import ntq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [THR_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [NODE_W-1:0]  node,
  input  logic [1:0]         tier,
  input  logic               urgent,
  input  logic [TAG_W-1:0]   task_tag,
  input  logic [BATCH_W-1:0] batch_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [TAG_W-1:0]   out_tag,
  output logic [NODE_W-1:0]  source_node,
  output logic [CNT_W-1:0]   moved_count,
  output logic               last
);

  // configuration
  logic [NCNT_W-1:0] active_nodes;
  logic [THR_W-1:0]  steal_threshold;

  // sequencer and command
  state_t             state, state_next;
  logic [NODE_W-1:0]  node_r;
  logic [1:0]         tier_r;
  logic               tried;
  logic [TAG_W-1:0]   tag_r;
  logic [BATCH_W-1:0] maxb_r;
  logic [NCNT_W-1:0]  nact;

  // dequeue
  logic [NODE_W-1:0]  cur_node;
  logic [1:0]         cur_tier;
  logic [BATCH_W-1:0] got;
  logic               stealing;
  logic [NCNT_W-1:0]  vic;
  logic [TAG_W-1:0]   pend_tag;
  logic [NODE_W-1:0]  pend_src;

  // rebalance
  logic [NCNT_W-1:0]  scan_i;
  logic [DEPTH_W-1:0] maxd, mind;
  logic [NODE_W-1:0]  deepest, shallowest;
  logic [CNT_W-1:0]   to_move, moved;

  // queue pointers
  logic [QDL-1:0]   heads  [NQ];
  logic [QDL-1:0]   tails  [NQ];
  logic [CNT_W-1:0] counts [NQ];

  logic [WORD_W-1:0] rdata;
  store_req_t        st_req;

  // control strobes
  logic              push_en, pop_en, emit;
  logic [QIW-1:0]    push_q, pop_q;
  logic [2:0]        e_status;
  logic [TAG_W-1:0]  e_tag;
  logic [NODE_W-1:0] e_src;
  logic [CNT_W-1:0]  e_moved;
  logic              e_last;

  // shared lookups
  logic               slot_free;
  logic [NCNT_W-1:0]  ncap;
  logic [QIW-1:0]     cq, dq, sq, vq, rq;
  logic               cq_full, cq_empty, sq_full, dq_empty;
  logic [DEPTH_W-1:0] depth2, depth3, gap;
  logic [1:0]         tier_eff;
  logic [BATCH_W-1:0] maxb_cap;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    if (active_nodes == '0) begin
      ncap = NCNT_W'(1);
    end else if (active_nodes > NCNT_W'(NODES_MAX)) begin
      ncap = NCNT_W'(NODES_MAX);
    end else begin
      ncap = active_nodes;
    end
  end

  assign tier_eff = urgent ? TIER_HIGH : ((tier == 2'd3) ? TIER_LOW : tier);
  assign maxb_cap = (batch_limit > BATCH_W'(BATCH_MAX)) ? BATCH_W'(BATCH_MAX) : batch_limit;

  assign cq = (state == S_ENQ) ? qidx(node_r, tier_r) : qidx(cur_node, cur_tier);
  assign dq = qidx(deepest, TIER_NORMAL);
  assign sq = qidx(shallowest, TIER_NORMAL);
  assign vq = qidx(vic[NODE_W-1:0], TIER_HIGH);
  assign rq = qidx(scan_i[NODE_W-1:0], TIER_HIGH);

  assign cq_full  = (counts[cq] == CNT_W'(QCAP));
  assign cq_empty = (counts[cq] == '0);
  assign sq_full  = (counts[sq] == CNT_W'(QCAP));
  assign dq_empty = (counts[dq] == '0);

  // high plus normal depth of the steal candidate; all tiers of the scanned node
  assign depth2 = DEPTH_W'(counts[vq]) + DEPTH_W'(counts[vq + QIW'(1)]);
  assign depth3 = DEPTH_W'(counts[rq]) + DEPTH_W'(counts[rq + QIW'(1)])
                + DEPTH_W'(counts[rq + QIW'(2)]);
  assign gap    = maxd - mind;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(opcode))
            OP_ENQ:   state_next = S_ENQ;
            OP_DEQ:   state_next = (NCNT_W'(node) < ncap && maxb_cap != '0) ?
                                   S_DQ_LOOK : S_DQ_DONE;
            OP_REBAL: state_next = (ncap < NCNT_W'(2)) ? S_RB_DONE : S_RB_SCAN;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_ENQ: begin
        if (slot_free) begin
          if (NCNT_W'(node_r) >= nact || !cq_full || tier_r == TIER_LOW || tried) begin
            state_next = S_IDLE;
          end
        end
      end
      S_DQ_LOOK: begin
        if (got == maxb_r) begin
          state_next = S_DQ_DONE;
        end else if (!cq_empty) begin
          state_next = S_DQ_WAIT;
        end else if (cur_tier == TIER_LOW) begin
          if (stealing) begin
            state_next = (got != '0) ? S_DQ_DONE : S_STEAL;
          end else begin
            state_next = (got == '0 && nact > NCNT_W'(1)) ? S_STEAL : S_DQ_DONE;
          end
        end
      end
      S_DQ_WAIT: begin
        if (got == '0 || slot_free) begin
          state_next = S_DQ_LOOK;
        end
      end
      S_STEAL: begin
        if (vic == nact) begin
          state_next = S_DQ_DONE;
        end else if (vic != NCNT_W'(node_r) && depth2 >= DEPTH_W'(steal_threshold)) begin
          state_next = S_DQ_LOOK;
        end
      end
      S_DQ_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_RB_SCAN: begin
        if (scan_i == nact) begin
          state_next = S_RB_CHECK;
        end
      end
      S_RB_CHECK: begin
        if (deepest == shallowest || gap < DEPTH_W'(steal_threshold)) begin
          state_next = S_RB_DONE;
        end else begin
          state_next = S_RB_POP;
        end
      end
      S_RB_POP: begin
        state_next = (moved < to_move && !dq_empty) ? S_RB_WAIT : S_RB_DONE;
      end
      S_RB_WAIT: begin
        state_next = sq_full ? S_RB_DONE : S_RB_POP;
      end
      S_RB_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    st_req   = '0;
    push_en  = 1'b0;
    push_q   = '0;
    pop_en   = 1'b0;
    pop_q    = '0;
    emit     = 1'b0;
    e_status = ST_NO_TASK;
    e_tag    = '0;
    e_src    = '0;
    e_moved  = '0;
    e_last   = 1'b1;
    case (state)
      S_ENQ: begin
        e_src = node_r;
        if (slot_free) begin
          if (NCNT_W'(node_r) >= nact) begin
            emit     = 1'b1;
            e_status = ST_REJECTED;
          end else if (!cq_full) begin
            push_en      = 1'b1;
            push_q       = cq;
            st_req.we    = 1'b1;
            st_req.waddr = {cq, tails[cq]};
            st_req.wdata = {node_r, tag_r};
            emit         = 1'b1;
            e_status     = ST_ENQUEUED;
          end else if (tier_r == TIER_LOW || tried) begin
            emit     = 1'b1;
            e_status = ST_REJECTED;
          end
        end
      end
      S_DQ_LOOK: begin
        if (got != maxb_r && !cq_empty) begin
          pop_en       = 1'b1;
          pop_q        = cq;
          st_req.re    = 1'b1;
          st_req.raddr = {cq, heads[cq]};
        end
      end
      S_DQ_WAIT: begin
        // release the previous task now that another one follows
        if (got != '0 && slot_free) begin
          emit     = 1'b1;
          e_status = ST_DELIVERED;
          e_tag    = pend_tag;
          e_src    = pend_src;
          e_last   = 1'b0;
        end
      end
      S_DQ_DONE: begin
        if (slot_free) begin
          emit = 1'b1;
          if (got != '0) begin
            e_status = ST_DELIVERED;
            e_tag    = pend_tag;
            e_src    = pend_src;
          end
        end
      end
      S_RB_POP: begin
        if (moved < to_move && !dq_empty) begin
          pop_en       = 1'b1;
          pop_q        = dq;
          st_req.re    = 1'b1;
          st_req.raddr = {dq, heads[dq]};
        end
      end
      S_RB_WAIT: begin
        // relabel with the destination; put back on the source if it is full
        push_en      = 1'b1;
        push_q       = sq_full ? dq : sq;
        st_req.we    = 1'b1;
        st_req.waddr = sq_full ? {dq, tails[dq]} : {sq, tails[sq]};
        st_req.wdata = {shallowest, rdata[TAG_W-1:0]};
      end
      S_RB_DONE: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_status = ST_REBAL;
          e_moved  = moved;
        end
      end
      default: begin
      end
    endcase
  end

  ntq_store u_store (
    .clk   (clk),
    .req   (st_req),
    .rdata (rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_nodes    <= NCNT_W'(1);
      steal_threshold <= THR_W'(4);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_NODES: active_nodes    <= cfg_data[NCNT_W-1:0];
        CFG_STEAL_THR:    steal_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NQ; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      if (push_en) begin
        tails[push_q]  <= tails[push_q] + QDL'(1);
        counts[push_q] <= counts[push_q] + CNT_W'(1);
      end
      if (pop_en) begin
        heads[pop_q]  <= heads[pop_q] + QDL'(1);
        counts[pop_q] <= counts[pop_q] - CNT_W'(1);
      end
    end
  end

  // result register: hold until taken, load on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= e_status;
      out_tag     <= e_tag;
      source_node <= e_src;
      moved_count <= e_moved;
      last        <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      got      <= '0;
      stealing <= 1'b0;
      tried    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            node_r     <= node;
            tier_r     <= tier_eff;
            tried      <= 1'b0;
            tag_r      <= task_tag;
            maxb_r     <= maxb_cap;
            nact       <= ncap;
            cur_node   <= node;
            cur_tier   <= TIER_HIGH;
            got        <= '0;
            stealing   <= 1'b0;
            vic        <= '0;
            scan_i     <= '0;
            maxd       <= '0;
            mind       <= '1;
            deepest    <= '0;
            shallowest <= '0;
            moved      <= '0;
          end
        end
        S_ENQ: begin
          // full queue: fall through one tier, once
          if (slot_free && NCNT_W'(node_r) < nact && cq_full &&
              tier_r != TIER_LOW && !tried) begin
            tier_r <= tier_r + 2'd1;
            tried  <= 1'b1;
          end
        end
        S_DQ_LOOK: begin
          if (got != maxb_r && cq_empty) begin
            if (cur_tier != TIER_LOW) begin
              cur_tier <= cur_tier + 2'd1;
            end else if (stealing) begin
              vic <= vic + NCNT_W'(1);
            end else if (got == '0 && nact > NCNT_W'(1)) begin
              stealing <= 1'b1;
              vic      <= '0;
            end
          end
        end
        S_DQ_WAIT: begin
          if (got == '0 || slot_free) begin
            pend_tag <= rdata[TAG_W-1:0];
            pend_src <= rdata[WORD_W-1:TAG_W];
            got      <= got + BATCH_W'(1);
          end
        end
        S_STEAL: begin
          if (vic != nact) begin
            if (vic != NCNT_W'(node_r) && depth2 >= DEPTH_W'(steal_threshold)) begin
              cur_node <= vic[NODE_W-1:0];
              cur_tier <= TIER_HIGH;
            end else begin
              vic <= vic + NCNT_W'(1);
            end
          end
        end
        S_RB_SCAN: begin
          if (scan_i != nact) begin
            if (depth3 > maxd) begin
              maxd    <= depth3;
              deepest <= scan_i[NODE_W-1:0];
            end
            if (depth3 < mind) begin
              mind       <= depth3;
              shallowest <= scan_i[NODE_W-1:0];
            end
            scan_i <= scan_i + NCNT_W'(1);
          end
        end
        S_RB_CHECK: begin
          to_move <= gap[DEPTH_W-1:1];
        end
        S_RB_WAIT: begin
          if (!sq_full) begin
            moved <= moved + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_en |-> counts[push_q] != CNT_W'(QCAP))
    else $error("push into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop_en |-> counts[pop_q] != '0)
    else $error("pop from an empty queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("result register overwritten before transfer");

  a_batch_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DQ_LOOK || state == S_DQ_WAIT || state == S_DQ_DONE) |-> got <= maxb_r)
    else $error("dequeue returned more tasks than the batch limit");

  a_single_queue_op: assert property (@(posedge clk) disable iff (rst)
    !(push_en && pop_en))
    else $error("push and pop in the same cycle");
`endif

endmodule
